FILE: src/spq_pkg.sv
package spq_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int KEY_BITS_DEF = 16;
  localparam int PRIO_W       = 32;
  localparam int KEY_PORT_W   = 16;
  localparam int OCC_W        = 7;

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_UPDATE = 2'd1;
  localparam logic [1:0] MODE_POP    = 2'd2;
  localparam logic [1:0] MODE_PEEK   = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_EMPTY   = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_MISSING = 2'd3;

  typedef enum logic [1:0] {
    OP_NOP    = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2
  } cell_op_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    cell_op_t          op;
    logic [PRIO_W-1:0] prio;
  } cell_cmd_t;

endpackage

FILE: src/spq_cell.sv
module spq_cell #(
  parameter int KEY_BITS = spq_pkg::KEY_BITS_DEF,
  parameter int CNT_W    = 7,
  parameter int POS      = 0
) (
  input  logic                       clk,
  input  spq_pkg::cell_cmd_t         cmd,
  input  logic [KEY_BITS-1:0]        cmd_key,
  input  logic [CNT_W-1:0]           count,
  input  logic                       left_ge,
  input  logic [KEY_BITS-1:0]        left_key,
  input  logic [spq_pkg::PRIO_W-1:0] left_prio,
  input  logic [KEY_BITS-1:0]        right_key,
  input  logic [spq_pkg::PRIO_W-1:0] right_prio,
  input  logic                       shift_left,
  output logic [KEY_BITS-1:0]        key_r,
  output logic [spq_pkg::PRIO_W-1:0] prio_r,
  output logic                       ge,
  output logic                       hit
);

  logic [KEY_BITS-1:0]        key_nxt;
  logic [spq_pkg::PRIO_W-1:0] prio_nxt;
  logic                       occupied;
  logic                       at_end;

  assign occupied = count > CNT_W'(POS);
  assign at_end   = count == CNT_W'(POS);
  assign ge       = occupied && (prio_r >= cmd.prio);
  assign hit      = occupied && (key_r == cmd_key);

  always_comb begin
    key_nxt  = key_r;
    prio_nxt = prio_r;
    case (cmd.op)
      spq_pkg::OP_INSERT: begin
        // everything from the insertion point on moves one place to the tail
        if (left_ge) begin
          key_nxt  = left_key;
          prio_nxt = left_prio;
        end else if (ge || at_end) begin
          key_nxt  = cmd_key;
          prio_nxt = cmd.prio;
        end
      end
      spq_pkg::OP_REMOVE: begin
        if (shift_left) begin
          key_nxt  = right_key;
          prio_nxt = right_prio;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    key_r  <= key_nxt;
    prio_r <= prio_nxt;
  end

endmodule

FILE: src/spq_prefix_or.sv
module spq_prefix_or #(
  parameter int WIDTH = spq_pkg::CAPACITY_DEF
) (
  input  logic [WIDTH-1:0] din,
  output logic [WIDTH-1:0] dout
);

  localparam int LEVELS = $clog2(WIDTH);

  logic [WIDTH-1:0] stage [LEVELS+1];

  assign stage[0] = din;

  // log-depth prefix: bit b becomes the OR of din[0..b]
  for (genvar l = 0; l < LEVELS; l++) begin : g_lvl
    localparam int D = 1 << l;
    for (genvar b = 0; b < WIDTH; b++) begin : g_bit
      if (b >= D) begin : g_or
        assign stage[l+1][b] = stage[l][b] | stage[l][b-D];
      end else begin : g_pass
        assign stage[l+1][b] = stage[l][b];
      end
    end
  end

  assign dout = stage[LEVELS];

endmodule

FILE: src/sorted_priority_queue_update_key.sv
// Sorted priority queue of (key, priority) pairs, lowest priority at the head.
// Input channel in_valid/in_ready carries mode, key and priority_req; the
// result channel out_valid/out_ready carries status, head entry and occupancy.
// Every input transfer yields exactly one result transfer.
// Storage is a row of CAPACITY cells; each cell compares its pair with the
// broadcast request and loads its own, the request's, or a neighbor's pair.
// Insert, pop, peek and every rejected operation finish in the accept cycle
// and appear on the output register in the cycle after. A found update has
// the chain remove the pair, then reinsert it. Throughput: one item per
// cycle while the receiver does not stall and no update is reinserting; the
// chain performs one shift per cycle, which sets this rate.
// Reset clears the entry count; cell contents are not cleared and are never
// read beyond the count. While the receiver stalls, the result is held and
// no new item is taken until it has been transferred or is being transferred.
module sorted_priority_queue_update_key #(
  parameter int CAPACITY = spq_pkg::CAPACITY_DEF,
  parameter int KEY_BITS = spq_pkg::KEY_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     in_mode,
  input  logic [spq_pkg::KEY_PORT_W-1:0] in_key,
  input  logic [spq_pkg::PRIO_W-1:0]     in_priority_req,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [1:0]                     out_status,
  output logic [spq_pkg::KEY_PORT_W-1:0] out_head_key,
  output logic [spq_pkg::PRIO_W-1:0]     out_head_priority,
  output logic [spq_pkg::OCC_W-1:0]      out_occupancy
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int PW    = spq_pkg::PRIO_W;
  localparam int KPW   = spq_pkg::KEY_PORT_W;

  typedef enum logic [1:0] {
    S_IDLE  = 2'b01,
    S_REINS = 2'b10
  } state_t;

  state_t                 state_r, state_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [KEY_BITS-1:0]    pend_key_r, pend_key_nxt;
  logic [PW-1:0]          pend_prio_r, pend_prio_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic [1:0]             status_r, status_nxt;
  logic [KPW-1:0]         hkey_r, hkey_nxt;
  logic [PW-1:0]          hprio_r, hprio_nxt;
  logic [CNT_W-1:0]       occ_r, occ_nxt;

  spq_pkg::cell_cmd_t     cmd;
  logic [KEY_BITS-1:0]    cmd_key;
  logic [KEY_BITS-1:0]    in_key_w;
  logic [KEY_BITS+KPW-1:0] in_key_ext;
  logic [KEY_BITS+KPW-1:0] head_key_ext;

  logic [KEY_BITS-1:0]    key_v  [CAPACITY];
  logic [PW-1:0]          prio_v [CAPACITY];
  logic [CAPACITY-1:0]    ge_v;
  logic [CAPACITY-1:0]    hit_v;
  logic [CAPACITY-1:0]    hit_pre;
  logic [CAPACITY-1:0]    shift_v;
  logic                   found;
  logic                   in_fire;
  logic                   full;
  logic                   empty;
  logic [CNT_W+spq_pkg::OCC_W-1:0] occ_ext;

  assign in_key_ext   = {{KEY_BITS{1'b0}}, in_key};
  assign in_key_w     = in_key_ext[KEY_BITS-1:0];
  assign head_key_ext = {{KPW{1'b0}}, key_v[0]};

  assign in_ready = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign in_fire  = in_valid && in_ready;
  assign full     = cnt_r == CNT_W'(CAPACITY);
  assign empty    = cnt_r == '0;
  assign found    = |hit_v;

  assign cmd_key  = (state_r == S_REINS) ? pend_key_r : in_key_w;

  spq_prefix_or #(.WIDTH(CAPACITY)) u_prefix (
    .din  (hit_v),
    .dout (hit_pre)
  );

  // pop removes the head: every cell takes its right neighbor
  assign shift_v = (in_mode == spq_pkg::MODE_POP) ? '1 : hit_pre;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    pend_key_nxt  = pend_key_r;
    pend_prio_nxt = pend_prio_r;
    out_valid_nxt = out_valid_r && !out_ready;
    status_nxt    = status_r;
    hkey_nxt      = hkey_r;
    hprio_nxt     = hprio_r;
    occ_nxt       = occ_r;
    cmd.op        = spq_pkg::OP_NOP;
    cmd.prio      = (state_r == S_REINS) ? pend_prio_r : in_priority_req;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          out_valid_nxt = 1'b1;
          status_nxt    = spq_pkg::ST_OK;
          hkey_nxt      = '0;
          hprio_nxt     = '0;
          case (in_mode)
            spq_pkg::MODE_INSERT: begin
              if (full) begin
                status_nxt = spq_pkg::ST_FULL;
              end else begin
                cmd.op  = spq_pkg::OP_INSERT;
                cnt_nxt = cnt_r + CNT_W'(1);
              end
            end
            spq_pkg::MODE_UPDATE: begin
              if (!found) begin
                status_nxt = spq_pkg::ST_MISSING;
              end else begin
                // drop the first match now, reinsert next cycle
                cmd.op        = spq_pkg::OP_REMOVE;
                cnt_nxt       = cnt_r - CNT_W'(1);
                pend_key_nxt  = in_key_w;
                pend_prio_nxt = in_priority_req;
                out_valid_nxt = 1'b0;
                state_nxt     = S_REINS;
              end
            end
            default: begin
              if (empty) begin
                status_nxt = spq_pkg::ST_EMPTY;
              end else begin
                hkey_nxt  = head_key_ext[KPW-1:0];
                hprio_nxt = prio_v[0];
                if (in_mode == spq_pkg::MODE_POP) begin
                  cmd.op  = spq_pkg::OP_REMOVE;
                  cnt_nxt = cnt_r - CNT_W'(1);
                end
              end
            end
          endcase
          occ_nxt = cnt_nxt;
        end
      end
      S_REINS: begin
        cmd.op        = spq_pkg::OP_INSERT;
        cnt_nxt       = cnt_r + CNT_W'(1);
        out_valid_nxt = 1'b1;
        status_nxt    = spq_pkg::ST_OK;
        hkey_nxt      = '0;
        hprio_nxt     = '0;
        occ_nxt       = cnt_nxt;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                left_ge;
    logic [KEY_BITS-1:0] left_key;
    logic [PW-1:0]       left_prio;
    logic [KEY_BITS-1:0] right_key;
    logic [PW-1:0]       right_prio;

    if (i == 0) begin : g_first
      assign left_ge   = 1'b0;
      assign left_key  = '0;
      assign left_prio = '0;
    end else begin : g_mid
      assign left_ge   = ge_v[i-1];
      assign left_key  = key_v[i-1];
      assign left_prio = prio_v[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_key  = key_v[i];
      assign right_prio = prio_v[i];
    end else begin : g_inner
      assign right_key  = key_v[i+1];
      assign right_prio = prio_v[i+1];
    end

    spq_cell #(
      .KEY_BITS (KEY_BITS),
      .CNT_W    (CNT_W),
      .POS      (i)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .cmd_key    (cmd_key),
      .count      (cnt_r),
      .left_ge    (left_ge),
      .left_key   (left_key),
      .left_prio  (left_prio),
      .right_key  (right_key),
      .right_prio (right_prio),
      .shift_left (shift_v[i]),
      .key_r      (key_v[i]),
      .prio_r     (prio_v[i]),
      .ge         (ge_v[i]),
      .hit        (hit_v[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_key_r  <= pend_key_nxt;
    pend_prio_r <= pend_prio_nxt;
    status_r    <= status_nxt;
    hkey_r      <= hkey_nxt;
    hprio_r     <= hprio_nxt;
    occ_r       <= occ_nxt;
  end

  assign occ_ext           = {{spq_pkg::OCC_W{1'b0}}, occ_r};
  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_head_key      = hkey_r;
  assign out_head_priority = hprio_r;
  assign out_occupancy     = occ_ext[spq_pkg::OCC_W-1:0];

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(CAPACITY))
    else $error("entry count beyond capacity");

  a_reins_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_REINS |=> state_r == S_IDLE && out_valid_r)
    else $error("reinsert did not complete in one cycle");

  a_update_split: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_mode == spq_pkg::MODE_UPDATE && found
      |=> state_r == S_REINS && !out_valid_r)
    else $error("found update did not enter reinsert");

  a_reins_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_REINS |-> !out_valid_r)
    else $error("output register busy during reinsert");

  a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE && cnt_r > CNT_W'(1) |-> prio_v[0] <= prio_v[1])
    else $error("head pair out of order");

endmodule
